/* design/dwe_pkg.sv */
package dwe_pkg;

   // default sizing of the dictionary and first-line buffer
   localparam int DEF_DICT_WORDS = 10;
   localparam int DEF_WORD_MAX   = 9;
   localparam int DEF_LINE_MAX   = 32;

   // character codes
   localparam logic [7:0] CODE_FIRST = 8'd20;
   localparam logic [7:0] CODE_LAST  = 8'd29;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // parsing phase of the text
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;
      logic emit_echo;
      logic start_expand;
      logic start_replay;
      logic emit_dict;
      logic emit_line;
      logic emit_tail;
   } dwe_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;
      logic act_echo;
      logic act_expand;
      logic act_replay;
      logic run_end;
   } dwe_stat_type;

endpackage

/* design/dwe_channel_if.sv */
interface dwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface dwe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       line_overflow;

   modport source (output valid, output out_byte, output last_of_run,
                   output line_overflow, input ready);
   modport sink (input valid, input out_byte, input last_of_run,
                 input line_overflow, output ready);
endinterface

/* design/dwe_ctrl.sv */
module dwe_ctrl
   import dwe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dwe_stat_type status,
   output dwe_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_REPLAY = 4'b0100,
      ST_TAIL   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            cmd.take  = req_valid && status.out_free;
            if (cmd.take) begin
               cmd.emit_echo    = status.act_echo;
               cmd.start_expand = status.act_expand;
               cmd.start_replay = status.act_replay;
               if (status.act_expand) begin
                  state_in = ST_EXPAND;
               end else if (status.act_replay) begin
                  state_in = ST_REPLAY;
               end
            end
         end
         ST_EXPAND: begin
            if (status.out_free) begin
               cmd.emit_dict = 1'b1;
               if (status.run_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPLAY: begin
            if (status.out_free) begin
               cmd.emit_line = 1'b1;
               if (status.run_end) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/dwe_datapath.sv */
module dwe_datapath
   import dwe_pkg::*;
#(
   parameter int DICT_WORDS = DEF_DICT_WORDS,
   parameter int WORD_MAX   = DEF_WORD_MAX,
   parameter int LINE_MAX   = DEF_LINE_MAX
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   in_byte,
   input  logic         end_of_input,
   input  dwe_cmd_type  cmd,
   output dwe_stat_type status,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last_of_run,
   output logic         rsp_line_overflow
);

   localparam int WC_W  = $clog2(DICT_WORDS + 1);
   localparam int WI_W  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
   localparam int LEN_W = $clog2(WORD_MAX + 1);
   localparam int LL_W  = $clog2(LINE_MAX + 1);
   localparam int LB_W  = $clog2(LINE_MAX);
   localparam int DA_W  = $clog2(DICT_WORDS * WORD_MAX);

   // control registers
   phase_type         phase_ff, phase_in;
   logic [WC_W-1:0]   wc_ff, wc_in;
   logic [LL_W-1:0]   ll_ff, ll_in;
   logic              nl_ff, nl_in;
   logic              ovf_ff, ovf_in;

   // run registers
   logic [LL_W-1:0]   idx_ff, idx_in;
   logic [LL_W-1:0]   run_len_ff, run_len_in;
   logic [DA_W-1:0]   base_ff, base_in;
   logic [7:0]        tail_ff, tail_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // storage
   logic [7:0]        dict_mem [DICT_WORDS*WORD_MAX];
   logic [7:0]        line_mem [LINE_MAX];
   logic [LEN_W-1:0]  len_ff [DICT_WORDS];
   logic [7:0]        dict_rd_ff;
   logic [7:0]        line_rd_ff;

   logic              dict_we, line_we, len_we;
   logic [DA_W-1:0]   dict_wa, dict_ra, k_base;
   logic              dict_rd_en, line_rd_en;
   logic [LB_W-1:0]   line_ra;
   logic [LEN_W-1:0]  len_wd;

   // request decode
   logic [3:0]        code_k;
   logic [WI_W-1:0]   k_idx;
   logic [LEN_W-1:0]  k_len;
   logic              is_code, k_below, k_equal;
   logic              is_body, is_raw, is_header, header_blank;
   logic              run_end, any_emit;
   logic [WC_W-1:0]   wc_inc;

   assign code_k    = 4'(in_byte - CODE_FIRST);
   assign is_code   = (in_byte >= CODE_FIRST) && (in_byte <= CODE_LAST);
   assign k_below   = code_k < 4'(wc_ff);
   assign k_equal   = code_k == 4'(wc_ff);
   assign k_idx     = code_k[WI_W-1:0];
   assign k_len     = len_ff[k_idx];
   assign k_base    = DA_W'(k_idx) * DA_W'(WORD_MAX);
   assign is_body   = (phase_ff == PH_BODY);
   assign is_raw    = (phase_ff == PH_RAW);
   assign is_header = !is_body && !is_raw;
   assign header_blank = is_header && (wc_ff == '0)
                         && ((in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB));
   assign run_end   = (idx_ff == run_len_ff - LL_W'(1));
   assign wc_inc    = wc_ff + WC_W'(1);

   // status to the controller
   always_comb begin
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.act_echo   = !end_of_input
                          && (is_raw
                              || (is_body && !(is_code && (k_below || k_equal)))
                              || (header_blank && (ll_ff == '0)));
      status.act_expand = !end_of_input && is_body && is_code && k_below
                          && (k_len != '0);
      status.act_replay = !end_of_input && header_blank && (ll_ff != '0);
      status.run_end    = run_end;
   end

   // header parsing and phase control
   always_comb begin
      phase_in = phase_ff;
      wc_in    = wc_ff;
      ll_in    = ll_ff;
      nl_in    = nl_ff;
      ovf_in   = ovf_ff;
      dict_we  = 1'b0;
      line_we  = 1'b0;
      len_we   = 1'b0;
      dict_wa  = DA_W'(wc_ff) * DA_W'(WORD_MAX) + DA_W'(ll_ff);
      len_wd   = (ll_ff < LL_W'(WORD_MAX)) ? LEN_W'(ll_ff) : LEN_W'(WORD_MAX);
      if (cmd.take) begin
         if (end_of_input) begin
            phase_in = PH_HEADER;
            wc_in    = '0;
            ll_in    = '0;
            nl_in    = 1'b0;
            ovf_in   = 1'b0;
         end else if (is_header) begin
            if (in_byte == CHAR_NL) begin
               // end of a dictionary line, or a blank line ending the header
               if (!nl_ff && (wc_ff < WC_W'(DICT_WORDS))) begin
                  len_we = 1'b1;
                  wc_in  = wc_inc;
                  if (wc_inc >= WC_W'(DICT_WORDS)) begin
                     phase_in = PH_BODY;
                  end
               end
               if (nl_ff) begin
                  phase_in = PH_BODY;
               end
               ll_in = '0;
               nl_in = 1'b1;
            end else if (header_blank) begin
               phase_in = PH_RAW;
            end else begin
               // letter of a dictionary word
               dict_we = (wc_ff < WC_W'(DICT_WORDS)) && (ll_ff < LL_W'(WORD_MAX));
               if (ll_ff < LL_W'(LINE_MAX)) begin
                  line_we = (wc_ff == '0);
                  ll_in   = ll_ff + LL_W'(1);
               end else if (wc_ff == '0) begin
                  ovf_in = 1'b1;
               end
               nl_in = 1'b0;
            end
         end
      end
   end

   // run sequencing for expansion and replay
   always_comb begin
      idx_in     = idx_ff;
      run_len_in = run_len_ff;
      base_in    = base_ff;
      tail_in    = tail_ff;
      dict_rd_en = 1'b0;
      line_rd_en = 1'b0;
      dict_ra    = base_ff + DA_W'(idx_ff) + DA_W'(1);
      line_ra    = idx_ff[LB_W-1:0] + LB_W'(1);
      if (cmd.start_expand) begin
         idx_in     = '0;
         run_len_in = LL_W'(k_len);
         base_in    = k_base;
         dict_ra    = k_base;
         dict_rd_en = 1'b1;
      end else if (cmd.start_replay) begin
         idx_in     = '0;
         run_len_in = ll_ff;
         tail_in    = in_byte;
         line_ra    = '0;
         line_rd_en = 1'b1;
      end else if ((cmd.emit_dict || cmd.emit_line) && !run_end) begin
         idx_in     = idx_ff + LL_W'(1);
         dict_rd_en = cmd.emit_dict;
         line_rd_en = cmd.emit_line;
      end
   end

   // output register loading
   assign any_emit = cmd.emit_echo || cmd.emit_dict || cmd.emit_line || cmd.emit_tail;

   always_comb begin
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      if (any_emit) begin
         rsp_ovf_in = ovf_ff;
      end
      if (cmd.emit_echo) begin
         rsp_byte_in = in_byte;
         rsp_last_in = 1'b1;
      end else if (cmd.emit_dict) begin
         rsp_byte_in = dict_rd_ff;
         rsp_last_in = run_end;
      end else if (cmd.emit_line) begin
         rsp_byte_in = line_rd_ff;
         rsp_last_in = 1'b0;
      end else if (cmd.emit_tail) begin
         rsp_byte_in = tail_ff;
         rsp_last_in = 1'b1;
      end
      if (any_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         wc_ff        <= '0;
         ll_ff        <= '0;
         nl_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wc_ff        <= wc_in;
         ll_ff        <= ll_in;
         nl_ff        <= nl_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_len_ff  <= run_len_in;
      base_ff     <= base_in;
      tail_ff     <= tail_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // dictionary letters
   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[dict_wa] <= in_byte;
      end
      if (dict_rd_en) begin
         dict_rd_ff <= dict_mem[dict_ra];
      end
   end

   // first-line buffer
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[ll_ff[LB_W-1:0]] <= in_byte;
      end
      if (line_rd_en) begin
         line_rd_ff <= line_mem[line_ra];
      end
   end

   // word lengths
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_ff[wc_ff[WI_W-1:0]] <= len_wd;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_line_overflow = rsp_ovf_ff;

endmodule

/* design/dictionary_word_expander.sv */
// channel    | direction | contents
// req_chan   | in        | in_byte, end_of_input
// rsp_chan   | out       | out_byte, last_of_run, line_overflow
//
// plain text streams at one byte a cycle while the output register is free; a
// word expansion or a raw replay of the first line is set by the single read port
// of the dictionary and line memories, one byte read and sent per cycle while the
// response does not stall, and no request is taken until the run has ended.
// reset is synchronous, clears the parser state and empties the output register;
// the memories are left as they are and need no clearing pass.
// a stalled response holds the output register, and no request is taken until
// that register is free or being drained in the same cycle.
module dictionary_word_expander
   import dwe_pkg::*;
#(
   parameter int DICT_WORDS = DEF_DICT_WORDS,
   parameter int WORD_MAX   = DEF_WORD_MAX,
   parameter int LINE_MAX   = DEF_LINE_MAX
) (
   input  logic      clock,
   input  logic      reset,
   dwe_req_if.sink   req_chan,
   dwe_rsp_if.source rsp_chan
);

   dwe_cmd_type  cmd;
   dwe_stat_type status;

   // sequencing of requests and output runs
   dwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, memories and output register
   dwe_datapath #(
      .DICT_WORDS (DICT_WORDS),
      .WORD_MAX   (WORD_MAX),
      .LINE_MAX   (LINE_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .in_byte           (req_chan.in_byte),
      .end_of_input      (req_chan.end_of_input),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_out_byte      (rsp_chan.out_byte),
      .rsp_last_of_run   (rsp_chan.last_of_run),
      .rsp_line_overflow (rsp_chan.line_overflow)
   );

endmodule

/* design/dwe_checker.sv */
module dwe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_input,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_line_overflow
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_out_byte) && $stable(rsp_last_of_run)
          && $stable(rsp_line_overflow)))
      else $error("response payload changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // end of text yields no byte
   a_eoi_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_input && (!rsp_valid || rsp_ready))
         |=> !rsp_valid)
      else $error("end of text produced a byte");

   // a request is only taken when the output register can accept a byte
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("request ready while output register blocked");

endmodule

bind dictionary_word_expander dwe_checker u_dwe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_end_of_input  (req_chan.end_of_input),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_byte      (rsp_chan.out_byte),
   .rsp_last_of_run   (rsp_chan.last_of_run),
   .rsp_line_overflow (rsp_chan.line_overflow)
);

/* verif/tb_dictionary_word_expander.sv */
module tb_dictionary_word_expander
   import dwe_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = DEF_DICT_WORDS;
   localparam int WM = DEF_WORD_MAX;
   localparam int LM = DEF_LINE_MAX;

   // pacing of the run
   localparam int MODE_SPAN   = 70;
   localparam int HOLD_AT     = 110;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 200;
   localparam int RANDOM_REQS = 130;

   // byte extremes for an over-long dictionary word
   localparam logic [7:0] EXTREME_BYTES [10] = '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'h55,
                                                 8'hAA, 8'h14, 8'h1D, 8'h01, 8'hFE};

   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } text_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       ovf;
   } out_byte_type;

   logic clock;
   logic reset;

   dwe_req_if req_if ();
   dwe_rsp_if rsp_if ();

   dictionary_word_expander dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   text_req_type text_requests[$];
   out_byte_type pending_out_bytes[$];
   int           accepted_requests = 0;
   int           errors = 0;

   // shadow copy of the parser state
   phase_type  parse_phase = PH_HEADER;
   int         word_total = 0;
   int         cur_line_len = 0;
   logic       saw_newline = 0;
   logic       first_line_lost = 0;
   logic [7:0] dict_word [DW][WM];
   int         dict_len [DW];
   logic [7:0] line_buf [LM];

   // work out the bytes one request produces and queue them
   function automatic void expand_text_byte(input logic [7:0] b, input logic eot);
      logic [7:0] run[$];
      int         k;
      if (eot) begin
         parse_phase     = PH_HEADER;
         word_total      = 0;
         cur_line_len    = 0;
         saw_newline     = 0;
         first_line_lost = 0;
         return;
      end
      case (parse_phase)
         PH_RAW: begin
            run.push_back(b);
         end
         PH_BODY: begin
            if (b >= CODE_FIRST && b <= CODE_LAST) begin
               k = int'(b - CODE_FIRST);
               if (k < word_total) begin
                  for (int i = 0; i < dict_len[k]; i++) run.push_back(dict_word[k][i]);
               end else if (k != word_total) begin
                  run.push_back(b);
               end
            end else begin
               run.push_back(b);
            end
         end
         default: begin
            if (b == CHAR_NL) begin
               // end of a dictionary line, or a blank line closing the header
               if (!saw_newline && word_total < DW) begin
                  dict_len[word_total] = (cur_line_len < WM) ? cur_line_len : WM;
                  word_total++;
                  if (word_total >= DW) parse_phase = PH_BODY;
               end
               cur_line_len = 0;
               if (saw_newline) parse_phase = PH_BODY;
               saw_newline = 1;
            end else if (word_total == 0 && (b == CHAR_SPACE || b == CHAR_TAB)) begin
               // first line is plain text: replay it and go raw
               for (int i = 0; i < cur_line_len && i < LM; i++) run.push_back(line_buf[i]);
               run.push_back(b);
               parse_phase = PH_RAW;
            end else begin
               if (word_total < DW && cur_line_len < WM)
                  dict_word[word_total][cur_line_len] = b;
               if (cur_line_len < LM) begin
                  if (word_total == 0) line_buf[cur_line_len] = b;
                  cur_line_len++;
               end else if (word_total == 0) begin
                  first_line_lost = 1;
               end
               saw_newline = 0;
            end
         end
      endcase
      foreach (run[i])
         pending_out_bytes.push_back('{run[i], i == run.size() - 1, first_line_lost});
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      text_requests.push_back('{b, 1'b0});
   endfunction

   function automatic void add_end();
      text_requests.push_back('{8'($urandom), 1'b1});
   endfunction

   // random byte for a dictionary line
   function automatic logic [7:0] word_char(input bit first_line);
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CHAR_NL || (first_line && (b == CHAR_SPACE || b == CHAR_TAB)));
      return b;
   endfunction

   // header of n words then a body rich in word codes
   function automatic void add_dict_text(input int words, input int first_len,
                                         input int body_len, input bit cut_short);
      int len;
      int pick;
      for (int w = 0; w < words; w++) begin
         if (w == 0) len = first_len;
         else len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                                 : $urandom_range(1, 9);
         for (int i = 0; i < len; i++) add_byte(word_char(w == 0));
         if (cut_short && w == words - 1) begin
            add_end();
            return;
         end
         add_byte(CHAR_NL);
      end
      if (words < DW) add_byte(CHAR_NL);
      for (int i = 0; i < body_len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) add_byte(CODE_FIRST + 8'($urandom_range(0, 9)));
         else if (pick == 5) add_byte(CHAR_NL);
         else add_byte(8'($urandom));
      end
      add_end();
   endfunction

   // first line broken by a space or tab, then raw text
   function automatic void add_raw_text(input int first_len, input int tail_len);
      for (int i = 0; i < first_len; i++) add_byte(word_char(1));
      add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      for (int i = 0; i < tail_len; i++) add_byte(8'($urandom));
      add_end();
   endfunction

   function automatic int first_line_len();
      if ($urandom_range(0, 5) == 0) return $urandom_range(30, 40);
      return $urandom_range(0, 12);
   endfunction

   function automatic int idle_mode();
      return (accepted_requests / MODE_SPAN) % 4;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin : req_driver
      text_req_type item;
      logic         offer;
      logic         pause;
      int           pct;
      static bit    drain_done = 0;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            item = text_requests.pop_front();
            expand_text_byte(item.data, item.eot);
            accepted_requests++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            // hold off once until every queued byte has come out
            pause = (accepted_requests == DRAIN_AT) && !drain_done;
            if (pause && pending_out_bytes.size() == 0) begin
               drain_done = 1;
               pause = 0;
            end
            pct = (idle_mode() == 1) ? 45 : (idle_mode() == 3) ? 19 : 0;
            offer = text_requests.size() != 0 && !pause && $urandom_range(0, 99) >= pct;
            req_if.valid <= offer;
            if (offer) begin
               req_if.in_byte      <= text_requests[0].data;
               req_if.end_of_input <= text_requests[0].eot;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      out_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_out_bytes.size() == 0) begin
            $display("%0t unexpected byte: got %h last %b ovf %b", $time,
                     rsp_if.out_byte, rsp_if.last_of_run, rsp_if.line_overflow);
            errors++;
         end else begin
            want = pending_out_bytes.pop_front();
            if (rsp_if.out_byte !== want.data) begin
               $display("%0t out_byte: expected %h got %h", $time, want.data,
                        rsp_if.out_byte);
               errors++;
            end
            if (rsp_if.last_of_run !== want.last) begin
               $display("%0t last_of_run: expected %b got %b", $time, want.last,
                        rsp_if.last_of_run);
               errors++;
            end
            if (rsp_if.line_overflow !== want.ovf) begin
               $display("%0t line_overflow: expected %b got %b", $time, want.ovf,
                        rsp_if.line_overflow);
               errors++;
            end
         end
      end
   end

   // receiver stalls, with one long hold-off so that the block backs up its input
   always @(posedge clock) begin : rsp_staller
      int        pct;
      static int hold_left = 0;
      static bit hold_done = 0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && accepted_requests >= HOLD_AT) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         pct = (idle_mode() == 2) ? 45 : (idle_mode() == 3) ? 19 : 0;
         rsp_if.ready <= $urandom_range(0, 99) >= pct;
      end
   end

   // stimulus and end of run
   initial begin
      int target;
      int pick;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.in_byte      = 8'h00;
      req_if.end_of_input = 1'b0;
      rsp_if.ready        = 1'b0;

      // empty first word, spaces inside a later word, an over-long word,
      // empty-word expansion, dropped and literal codes, byte extremes
      add_byte(CHAR_NL);
      add_byte("x");
      add_byte(CHAR_SPACE);
      add_byte(CHAR_TAB);
      add_byte(CHAR_NL);
      for (int i = 0; i < 10; i++) add_byte(EXTREME_BYTES[i]);
      add_byte(CHAR_NL);
      add_byte(CHAR_NL);
      add_byte(CODE_FIRST);
      add_byte(CODE_FIRST + 8'd1);
      add_byte(CODE_FIRST + 8'd2);
      add_byte(CODE_FIRST + 8'd3);
      add_byte(CODE_LAST);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(CHAR_NL);
      add_end();

      // longest replay with lost bytes, then a full dictionary
      add_raw_text(LM + 4, 4);
      add_dict_text(DW, WM, 12, 0);

      target = text_requests.size() + RANDOM_REQS;
      while (text_requests.size() < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            add_dict_text($urandom_range(1, DW), first_line_len(), $urandom_range(5, 25), 0);
         else if (pick < 8)
            add_raw_text(first_line_len(), $urandom_range(2, 10));
         else if (pick == 8)
            add_dict_text($urandom_range(1, DW), first_line_len(), 0, 1);
         else begin
            // noise with stray ends of text
            repeat ($urandom_range(4, 15)) begin
               if ($urandom_range(0, 7) == 0) add_end();
               else add_byte(8'($urandom));
            end
            add_end();
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (text_requests.size() != 0 || pending_out_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("dictionary_word_expander: match");
      end else begin
         $display("dictionary_word_expander: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #3ms;
      $display("dictionary_word_expander: mismatch");
      $finish;
   end

endmodule
